/* sv/paraxial_ray_trace_lens_group_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the paraxial ray trace lens group
// Clocked on clk; the first form is masked during reset, the second is not.
// ----------------------------------------------------------------------------
`ifndef PARAXIAL_RAY_TRACE_LENS_GROUP_TOP_MACROS_SVH
`define PARAXIAL_RAY_TRACE_LENS_GROUP_TOP_MACROS_SVH

// Property checked out of reset only
`define PRTL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define PRTL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/prtl_pkg.sv */
// ----------------------------------------------------------------------------
// prtl_pkg
// Types, codes and saturation helper shared by the lens group ray tracer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prtl_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int Q_FRAC = 16;
	localparam int DVD_W = 32 + Q_FRAC;
	localparam int SAT_W = 50;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_NO_LENS    = 2'd1,
		STATUS_ZERO_FOCUS = 2'd2,
		STATUS_AFOCAL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_APERTURE  = 2'd0,
		KIND_LENS      = 2'd1,
		KIND_ZERO_LENS = 2'd2
	} kind_t;

	typedef struct packed {
		logic               is_aperture;
		logic signed [31:0] focus_len;
		logic [30:0]        diameter;
		logic signed [31:0] position;
		logic               last_element;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] effective_focal_length;
		logic signed [31:0] back_focal_length;
		status_t            status;
	} out_item_t;

	// classified element as held in the queue
	typedef struct packed {
		kind_t              kind;
		logic [29:0]        half;
		logic signed [31:0] focus_len;
		logic signed [31:0] position;
		logic               last_element;
	} entry_t;

	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = $signed({{(SAT_W-32){1'b0}}, 32'h7FFF_FFFF});
		lo = $signed({{(SAT_W-32){1'b1}}, 32'h8000_0000});
		if (v > hi)
			return 32'sh7FFF_FFFF;
		else if (v < lo)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

endpackage

/* sv/prtl_stream_if.sv */
// ----------------------------------------------------------------------------
// prtl_stream_if
// Valid/ready channel; a transaction completes when both are high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface prtl_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* sv/paraxial_ray_trace_lens_group_top.sv */
// ----------------------------------------------------------------------------
// Steps: an aperture passes load and finish; a lens adds one 48-step divide
//   for the refraction, a later lens also the registered transfer multiply;
//   a last element with status OK adds the two focal divisions and the
//   output register. Throughput: one element at a time in the trace engine;
//   the divider sets the lens rate. Reset: asynchronous, clears trace state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Paraxial marginal-ray trace through a lens group.
//
// Front: takes element transactions, tags each as aperture, lens or lens
// with zero focal length, pre-halves the diameter and queues it.
// Back: pops one entry at a time and runs the y-nu update:
//   aperture  - clip height to +/- half diameter once a lens has been seen
//   lens      - transfer height over the gap to the previous lens
//               (one registered 32x33 multiply), then refract the slope
//               through the shared iterative divider
//   last      - status, then efl and bfl through the same divider
// The queue lets new elements arrive while the divider grinds, and the
// result register lets the engine carry on while a result awaits pickup.
// Height, slope and the quotients saturate to signed 32 bits, Q16.16.

module paraxial_ray_trace_lens_group_top #(
	parameter int QUEUE_DEPTH = prtl_pkg::QUEUE_DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	prtl_stream_if.sink   item_ch,
	prtl_stream_if.source result_ch
);

	// classified elements between front and back
	prtl_stream_if #(.payload_t(prtl_pkg::entry_t)) q_ch ();

	prtl_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_ch (item_ch),
		.q_ch    (q_ch)
	);

	prtl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_ch      (q_ch),
		.result_ch (result_ch)
	);

endmodule

/* sv/prtl_div.sv */
// ----------------------------------------------------------------------------
// prtl_div
// Radix-2 restoring divider: sat32(+/- trunc(num * 2^16 / den)), one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prtl_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	input  logic               neg,
	output logic               done,
	output logic signed [31:0] quot
);

	localparam int W = prtl_pkg::DVD_W;
	localparam int CNT_W = $clog2(W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      rem_q;
	logic [W-1:0]     dvd_q;
	logic [31:0]      dsr_q;
	logic             sign_q;

	logic [32:0] shifted;
	logic [32:0] trial;
	logic [31:0] num_mag;
	logic [31:0] den_mag;

	assign num_mag = num[31] ? 32'(-num) : 32'(num);
	assign den_mag = den[31] ? 32'(-den) : 32'(den);
	assign shifted = {rem_q, dvd_q[W-1]};
	assign trial   = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			dvd_q  <= {num_mag, {prtl_pkg::Q_FRAC{1'b0}}};
			dsr_q  <= den_mag;
			sign_q <= num[31] ^ den[31] ^ neg;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				dvd_q <= {dvd_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				dvd_q <= {dvd_q[W-2:0], 1'b0};
			end
		end
	end

	// saturate the signed quotient
	always_comb begin
		if (!sign_q) begin
			if (dvd_q > W'(32'h7FFF_FFFF))
				quot = 32'sh7FFF_FFFF;
			else
				quot = $signed(dvd_q[31:0]);
		end else begin
			if (dvd_q > W'(33'h1_0000_0000 >> 1))
				quot = 32'sh8000_0000;
			else
				quot = $signed(32'(-dvd_q[31:0]));
		end
	end

	assign done = done_q;

endmodule

/* sv/prtl_front.sv */
// ----------------------------------------------------------------------------
// prtl_front
// Accepts elements, classifies them and queues them for the trace engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prtl_front #(
	parameter int DEPTH = prtl_pkg::QUEUE_DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	prtl_stream_if.sink   item_ch,
	prtl_stream_if.source q_ch
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	prtl_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	prtl_pkg::entry_t cls;
	logic             push;
	logic             pop;

	// classification
	always_comb begin
		cls.half         = item_ch.payload.diameter[30:1];
		cls.focus_len    = item_ch.payload.focus_len;
		cls.position     = item_ch.payload.position;
		cls.last_element = item_ch.payload.last_element;
		if (item_ch.payload.is_aperture)
			cls.kind = prtl_pkg::KIND_APERTURE;
		else if (item_ch.payload.focus_len == 32'sd0)
			cls.kind = prtl_pkg::KIND_ZERO_LENS;
		else
			cls.kind = prtl_pkg::KIND_LENS;
	end

	assign item_ch.ready = (count_q != CNT_W'(DEPTH));
	assign push          = item_ch.valid && item_ch.ready;
	assign q_ch.valid    = (count_q != '0);
	assign q_ch.payload  = mem_q[rd_ptr_q];
	assign pop           = q_ch.valid && q_ch.ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* sv/prtl_back.sv */
// ----------------------------------------------------------------------------
// prtl_back
// y-nu trace sequencer: clip, transfer, refract and the closing focal divisions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prtl_back (
	input logic          clk,
	input logic          arst_n,
	prtl_stream_if.sink   q_ch,
	prtl_stream_if.source result_ch
);

	localparam int SW = prtl_pkg::SAT_W;

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b0000_0000_0001,
		ST_LOAD   = 12'b0000_0000_0010,
		ST_MUL    = 12'b0000_0000_0100,
		ST_XFER   = 12'b0000_0000_1000,
		ST_DSTART = 12'b0000_0001_0000,
		ST_REFR   = 12'b0000_0010_0000,
		ST_FIN    = 12'b0000_0100_0000,
		ST_ESTART = 12'b0000_1000_0000,
		ST_EFL    = 12'b0001_0000_0000,
		ST_BSTART = 12'b0010_0000_0000,
		ST_BFL    = 12'b0100_0000_0000,
		ST_RES    = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	prtl_pkg::entry_t item_q;
	logic               lens_seen_q;
	logic               fault_q;
	logic signed [31:0] entry_q;
	logic signed [31:0] height_q;
	logic signed [31:0] slope_q;
	logic signed [31:0] prev_q;
	logic signed [64:0] prod_q;
	logic signed [31:0] efl_q;
	logic signed [31:0] bfl_q;
	prtl_pkg::status_t  status_q;

	logic               res_valid_q;
	prtl_pkg::out_item_t res_q;

	logic               div_start;
	logic signed [31:0] div_num;
	logic signed [31:0] div_den;
	logic               div_neg;
	logic               div_done;
	logic signed [31:0] div_quot;

	logic signed [31:0] half_s;
	logic signed [32:0] gap;
	logic signed [SW-1:0] xfer_sum;
	logic signed [SW-1:0] refr_diff;
	logic               res_free;

	assign half_s    = $signed({2'b00, item_q.half});
	assign gap       = {prev_q[31], prev_q} - {item_q.position[31], item_q.position};
	assign xfer_sum  = {{(SW-32){height_q[31]}}, height_q}
		+ {{(SW-49){prod_q[64]}}, prod_q[64:16]};
	assign refr_diff = {{(SW-32){slope_q[31]}}, slope_q}
		- {{(SW-32){div_quot[31]}}, div_quot};
	assign res_free  = !res_valid_q || result_ch.ready;

	assign q_ch.ready = (state_q == ST_IDLE);

	assign div_start = (state_q == ST_DSTART) || (state_q == ST_ESTART)
		|| (state_q == ST_BSTART);
	assign div_num   = (state_q == ST_ESTART) ? entry_q : height_q;
	assign div_den   = (state_q == ST_DSTART) ? item_q.focus_len : slope_q;
	assign div_neg   = (state_q != ST_DSTART);

	prtl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.neg    (div_neg),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk) begin
		if (q_ch.valid && q_ch.ready)
			item_q <= q_ch.payload;
		if (state_q == ST_MUL)
			prod_q <= slope_q * gap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lens_seen_q <= 1'b0;
			fault_q     <= 1'b0;
			entry_q     <= '0;
			height_q    <= '0;
			slope_q     <= '0;
			prev_q      <= '0;
			efl_q       <= '0;
			bfl_q       <= '0;
			status_q    <= prtl_pkg::STATUS_OK;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RES && res_free)
				res_valid_q <= 1'b1;
			else if (result_ch.ready)
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_ch.valid)
						state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					unique case (item_q.kind) inside
						prtl_pkg::KIND_APERTURE: begin
							if (lens_seen_q) begin
								if (height_q > half_s)
									height_q <= half_s;
								else if (height_q < -half_s)
									height_q <= -half_s;
							end
							state_q <= ST_FIN;
						end
						prtl_pkg::KIND_LENS, prtl_pkg::KIND_ZERO_LENS: begin
							if (!lens_seen_q) begin
								lens_seen_q <= 1'b1;
								entry_q     <= half_s;
								height_q    <= half_s;
								slope_q     <= '0;
								prev_q      <= item_q.position;
								if (item_q.kind == prtl_pkg::KIND_ZERO_LENS) begin
									fault_q <= 1'b1;
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_DSTART;
								end
							end else begin
								state_q <= ST_MUL;
							end
						end
						default: state_q <= ST_FIN;
					endcase
				end
				ST_MUL: state_q <= ST_XFER;
				ST_XFER: begin
					height_q <= prtl_pkg::sat32(xfer_sum);
					prev_q   <= item_q.position;
					if (item_q.kind == prtl_pkg::KIND_ZERO_LENS) begin
						fault_q <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DSTART;
					end
				end
				ST_DSTART: state_q <= ST_REFR;
				ST_REFR: begin
					if (div_done) begin
						slope_q <= prtl_pkg::sat32(refr_diff);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					efl_q <= '0;
					bfl_q <= '0;
					if (!item_q.last_element) begin
						state_q <= ST_IDLE;
					end else if (!lens_seen_q) begin
						status_q <= prtl_pkg::STATUS_NO_LENS;
						state_q  <= ST_RES;
					end else if (fault_q) begin
						status_q <= prtl_pkg::STATUS_ZERO_FOCUS;
						state_q  <= ST_RES;
					end else if (slope_q == 32'sd0) begin
						status_q <= prtl_pkg::STATUS_AFOCAL;
						state_q  <= ST_RES;
					end else begin
						status_q <= prtl_pkg::STATUS_OK;
						state_q  <= ST_ESTART;
					end
				end
				ST_ESTART: state_q <= ST_EFL;
				ST_EFL: begin
					if (div_done) begin
						efl_q   <= div_quot;
						state_q <= ST_BSTART;
					end
				end
				ST_BSTART: state_q <= ST_BFL;
				ST_BFL: begin
					if (div_done) begin
						bfl_q   <= div_quot;
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (res_free) begin
						lens_seen_q <= 1'b0;
						fault_q     <= 1'b0;
						entry_q     <= '0;
						height_q    <= '0;
						slope_q     <= '0;
						prev_q      <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RES && res_free) begin
			res_q.effective_focal_length <= efl_q;
			res_q.back_focal_length      <= bfl_q;
			res_q.status                 <= status_q;
		end
	end

	assign result_ch.valid   = res_valid_q;
	assign result_ch.payload = res_q;

endmodule

/* sv/prtl_checker.sv */
// ----------------------------------------------------------------------------
// prtl_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "paraxial_ray_trace_lens_group_top_macros.svh"

module prtl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] efl,
	input logic [31:0] bfl,
	input logic [1:0]  status
);

	// stalled result transaction stays up and unchanged
	`PRTL_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid, "result valid dropped while stalled")
	`PRTL_ASSERT(a_res_stable, res_valid && !res_ready |=> $stable(efl) && $stable(bfl) && $stable(status), "result payload changed while stalled")

	// any error status carries zero focal lengths
	`PRTL_ASSERT(a_err_zero, res_valid && (status != prtl_pkg::STATUS_OK) |-> (efl == 32'd0) && (bfl == 32'd0), "error status with nonzero focal length")

	// nothing is offered while held in reset
	`PRTL_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !res_valid, "result valid during reset")

endmodule

bind paraxial_ray_trace_lens_group_top prtl_checker u_prtl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result_ch.valid),
	.res_ready (result_ch.ready),
	.efl       (result_ch.payload.effective_focal_length),
	.bfl       (result_ch.payload.back_focal_length),
	.status    (result_ch.payload.status)
);

/* sim/paraxial_ray_trace_lens_group_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paraxial_ray_trace_lens_group_top_tb
// Self-checking bench for the lens group ray tracer. Element transactions go
// in on the item channel. A scoreboard class keeps its own y-nu trace and
// predicts the focal lengths and status that each last element must give.
// Results are checked in order against that prediction. A short directed
// part comes first. Random groups follow under four idle and stall mixes.
// ----------------------------------------------------------------------------

module paraxial_ray_trace_lens_group_top_tb;

	localparam int     CLK_PERIOD    = 12;
	localparam int     MM            = 65536;     // 1.0 mm in Q16.16
	localparam int     STALL_LIMIT   = 3000;      // cycles with no transaction at all
	localparam int     SETTLE_CYCLES = 300;       // longer than a last-lens round trip
	localparam int     REPORT_MAX    = 10;
	localparam int     PHASE_ITEMS   = 450;
	localparam longint S32_MAX       = 64'sd2147483647;
	localparam longint S32_MIN       = -64'sd2147483648;

	// ------------------------------------------------------------------------
	// Scoreboard: tracks the marginal ray as the block should, and queues
	// the result that each last element is due to produce.
	// ------------------------------------------------------------------------
	class ynu_trace_scoreboard;
		bit                  lens_seen;
		longint              entry_h;
		longint              ray_h;
		longint              slope;
		longint              prev_pos;
		bit                  zero_focus;
		prtl_pkg::out_item_t focal_q[$];
		int                  mismatches;
		int                  results_seen;

		function new();
			clear_trace();
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void clear_trace();
			lens_seen  = 1'b0;
			entry_h    = 0;
			ray_h      = 0;
			slope      = 0;
			prev_pos   = 0;
			zero_focus = 1'b0;
		endfunction

		function longint clamp_s32(longint v);
			if (v > S32_MAX)
				return S32_MAX;
			if (v < S32_MIN)
				return S32_MIN;
			return v;
		endfunction

		// truncating Q16.16 quotient; operands stay well inside 64 bits
		function longint q16_ratio(longint num, longint den);
			return (num * 65536) / den;
		endfunction

		function void refract(longint f);
			if (f == 0) begin
				zero_focus = 1'b1;
				return;
			end
			slope = clamp_s32(slope - clamp_s32(q16_ratio(ray_h, f)));
		endfunction

		function void note_element(prtl_pkg::in_item_t e);
			longint              f;
			longint              half;
			longint              pos;
			longint              efl;
			longint              bfl;
			prtl_pkg::status_t   st;
			prtl_pkg::out_item_t want;
			f    = longint'(e.focus_len);
			half = longint'(e.diameter[30:1]);
			pos  = longint'(e.position);
			if (e.is_aperture) begin
				// apertures ahead of the first lens have nothing to clip
				if (lens_seen) begin
					if (ray_h > half)
						ray_h = half;
					else if (ray_h < -half)
						ray_h = -half;
				end
			end else if (!lens_seen) begin
				lens_seen = 1'b1;
				entry_h   = half;
				ray_h     = half;
				slope     = 0;
				refract(f);
				prev_pos  = pos;
			end else begin
				// >>> on a signed 64-bit product is the floor division by 2^16
				ray_h    = clamp_s32(ray_h + ((slope * (prev_pos - pos)) >>> 16));
				refract(f);
				prev_pos = pos;
			end
			if (!e.last_element)
				return;
			efl = 0;
			bfl = 0;
			if (!lens_seen)
				st = prtl_pkg::STATUS_NO_LENS;
			else if (zero_focus)
				st = prtl_pkg::STATUS_ZERO_FOCUS;
			else if (slope == 0)
				st = prtl_pkg::STATUS_AFOCAL;
			else begin
				st  = prtl_pkg::STATUS_OK;
				efl = clamp_s32(-q16_ratio(entry_h, slope));
				bfl = clamp_s32(-q16_ratio(ray_h, slope));
			end
			want.effective_focal_length = efl[31:0];
			want.back_focal_length      = bfl[31:0];
			want.status                 = st;
			focal_q.push_back(want);
			clear_trace();
		endfunction

		function void check_result(prtl_pkg::out_item_t got);
			prtl_pkg::out_item_t want;
			results_seen++;
			if (focal_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result %0d: none expected, got efl %0d bfl %0d status %0d",
						results_seen, $signed(got.effective_focal_length),
						$signed(got.back_focal_length), got.status);
				return;
			end
			want = focal_q.pop_front();
			if (got.effective_focal_length !== want.effective_focal_length ||
				got.back_focal_length !== want.back_focal_length ||
				got.status !== want.status) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display({"result %0d: efl exp %0d got %0d, ",
						"bfl exp %0d got %0d, status exp %0d got %0d"},
						results_seen,
						$signed(want.effective_focal_length),
						$signed(got.effective_focal_length),
						$signed(want.back_focal_length),
						$signed(got.back_focal_length),
						want.status, got.status);
			end
		endfunction

		function int pending();
			return focal_q.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels and the block
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;

	int idle_pct;      // chance per cycle that the sender holds off
	int stall_pct;     // chance per cycle that the receiver drops ready

	ynu_trace_scoreboard trace_sb = new();

	prtl_stream_if #(.payload_t(prtl_pkg::in_item_t))  item_ch ();
	prtl_stream_if #(.payload_t(prtl_pkg::out_item_t)) result_ch ();

	always #(CLK_PERIOD / 2) clk = ~clk;

	paraxial_ray_trace_lens_group_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_ch   (item_ch),
		.result_ch (result_ch)
	);

	// Receiver: ready redrawn every cycle from the current stall rate.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Monitor: both channels sampled at the edge, so only pre-edge values
	// are seen. Inputs are noted before results are checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				trace_sb.note_element(item_ch.payload);
			if (result_ch.valid && result_ch.ready)
				trace_sb.check_result(result_ch.payload);
		end
	end

	// Watchdog: a long run of edges with no transaction on either side
	// means the block has hung.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("paraxial_ray_trace_lens_group_top: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic prtl_pkg::in_item_t make_element(bit ap, logic signed [31:0] f,
		logic [30:0] d, logic signed [31:0] p, bit last);
		prtl_pkg::in_item_t e;
		e.is_aperture  = ap;
		e.focus_len    = f;
		e.diameter     = d;
		e.position     = p;
		e.last_element = last;
		return e;
	endfunction

	// Mostly ordinary lenses of 5 to 600 mm; a few zero and a few tiny
	// focal lengths to drive the fault flag and the saturation paths.
	function automatic logic signed [31:0] rand_focal();
		int                 pick;
		logic signed [31:0] mag;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			return '0;
		if (pick < 6)
			mag = $urandom_range(1, 1000);
		else
			mag = $urandom_range(5 * MM, 600 * MM);
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// One transaction. Valid stays high straight into the next element
	// unless the sender decides to idle first.
	task automatic send_element(prtl_pkg::in_item_t e);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.payload <= e;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
	endtask

	// Sender goes quiet until every predicted result has come back.
	task automatic pause_for_results();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (trace_sb.pending() != 0)
			@(posedge clk);
	endtask

	// One random lens group. Most are well formed: optional leading stop,
	// a lens, then lenses and stops at falling positions, with the last
	// flag on the final element. The rest is raw noise on every field.
	task automatic send_trace_group(output int n_sent);
		int                 n_el;
		int                 k;
		int                 pos;
		bit                 tiny_entry;
		prtl_pkg::in_item_t e;
		n_sent = 0;
		if ($urandom_range(0, 99) < 15) begin
			n_el = $urandom_range(1, 4);
			for (k = 0; k < n_el; k++) begin
				e.is_aperture  = 1'($urandom_range(0, 1));
				e.focus_len    = $urandom;
				e.diameter     = 31'($urandom);
				e.position     = $urandom;
				e.last_element = (k == n_el - 1) || ($urandom_range(0, 99) < 20);
				send_element(e);
			end
			n_sent = n_el;
			return;
		end
		pos        = $urandom_range(50 * MM, 400 * MM);
		tiny_entry = ($urandom_range(0, 99) < 6);   // entry height too small to bend
		if ($urandom_range(0, 99) < 30) begin
			send_element(make_element(1'b1, $urandom, 31'($urandom_range(0, 40 * MM)),
				pos + MM, 1'b0));
			n_sent = 1;
		end
		n_el = $urandom_range(1, 6);
		for (k = 0; k < n_el; k++) begin
			e.is_aperture  = (k > 0) && ($urandom_range(0, 99) < 30);
			e.focus_len    = rand_focal();
			if (e.is_aperture)
				e.diameter = 31'($urandom_range(0, 40 * MM));
			else if (k == 0 && tiny_entry)
				e.diameter = 31'($urandom_range(0, 3));
			else
				e.diameter = 31'($urandom_range(MM, 80 * MM));
			e.position     = pos;
			e.last_element = (k == n_el - 1);
			send_element(e);
			pos = pos - int'($urandom_range(0, 60 * MM));
		end
		n_sent += n_el;
	endtask

	task automatic run_random_phase(int n_items, int idle, int stall);
		int sent;
		int n;
		idle_pct  = idle;
		stall_pct = stall;
		sent      = 0;
		while (sent < n_items) begin
			send_trace_group(n);
			sent += n;
		end
		pause_for_results();
	endtask

	// Directed groups: every status, the priority of zero focus over
	// afocal, skipped and trailing stops, and full-scale fields.
	task automatic run_directed();
		idle_pct  = 0;
		stall_pct = 0;
		// no lens: a lone stop, then two stops at full-scale fields
		send_element(make_element(1'b1, '0, 31'(10 * MM), '0, 1'b1));
		send_element(make_element(1'b1, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000, 1'b0));
		send_element(make_element(1'b1, 32'sh8000_0000, '0, 32'sh7FFF_FFFF, 1'b1));
		// zero focal length; slope also stays zero, fault must win
		send_element(make_element(1'b0, '0, 31'(20 * MM), 100 * MM, 1'b1));
		// plain single lens
		send_element(make_element(1'b0, 100 * MM, 31'(20 * MM), 100 * MM, 1'b1));
		// stop before the lens is skipped, then clip, second lens, trailing clip
		send_element(make_element(1'b1, '0, 31'(2 * MM), 150 * MM, 1'b0));
		send_element(make_element(1'b0, 50 * MM, 31'(25 * MM), 120 * MM, 1'b0));
		send_element(make_element(1'b1, '0, 31'(10 * MM), 100 * MM, 1'b0));
		send_element(make_element(1'b0, -40 * MM, 31'(30 * MM), 80 * MM, 1'b0));
		send_element(make_element(1'b1, '0, 31'(4 * MM), 10 * MM, 1'b1));
		// afocal: entry height too small for the longest focal length
		send_element(make_element(1'b0, 32'sh7FFF_FFFF, 31'd3, '0, 1'b1));
		// saturation across the full position span
		send_element(make_element(1'b0, 32'sd1, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0));
		send_element(make_element(1'b0, 32'sh8000_0000, '0, 32'sh8000_0000, 1'b1));
		send_element(make_element(1'b0, -32'sd1, 31'h7FFF_FFFF, '0, 1'b1));
		// stop of zero diameter drives the height to zero
		send_element(make_element(1'b0, 50 * MM, 31'(40 * MM), 60 * MM, 1'b0));
		send_element(make_element(1'b1, '0, '0, 30 * MM, 1'b1));
		// zero-focus fault carried through a later good lens
		send_element(make_element(1'b0, '0, 31'(20 * MM), 90 * MM, 1'b0));
		send_element(make_element(1'b0, 30 * MM, 31'(20 * MM), 40 * MM, 1'b1));
		pause_for_results();
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		idle_pct        = 0;
		stall_pct       = 0;
		arst_n          <= 1'b0;
		item_ch.valid   <= 1'b0;
		item_ch.payload <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random_phase(PHASE_ITEMS, 0, 0);
		run_random_phase(PHASE_ITEMS, 58, 0);
		run_random_phase(PHASE_ITEMS, 0, 58);
		run_random_phase(PHASE_ITEMS, 37, 37);

		// anything still arriving now was never predicted
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (trace_sb.mismatches == 0 && trace_sb.pending() == 0)
			$display("paraxial_ray_trace_lens_group_top: match");
		else
			$display("paraxial_ray_trace_lens_group_top: mismatch");
		$finish;
	end

endmodule
